/* design/prmfe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package prmfe_pkg;
	localparam int RULE_SLOTS       = 8;
	localparam int FILTERS_PER_RULE = 16;
	localparam int FIELDS_PER_RULE  = 16;
	localparam int PACKET_BYTES     = 1024;
	localparam int PAW = $clog2(PACKET_BYTES);
	localparam int LW  = PAW + 1;
	localparam int RW  = $clog2(RULE_SLOTS);
	localparam int FW  = $clog2(FILTERS_PER_RULE);
	localparam int DW  = $clog2(FIELDS_PER_RULE);
	localparam int FTW = RW + FW;
	localparam int DTW = RW + DW;

	typedef enum logic [1:0] {
		OP_FILTER = 2'd0,
		OP_FIELD  = 2'd1,
		OP_COUNTS = 2'd2,
		OP_BYTE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RK_NONE  = 2'd0,
		RK_FIELD = 2'd1,
		RK_SHORT = 2'd2,
		RK_TRAIL = 2'd3
	} rkind_t;

	localparam logic REG_RULE_COUNT = 1'b0;
	localparam logic REG_PARSER_ON  = 1'b1;

	typedef struct packed {
		logic [1:0]  operation;
		logic [2:0]  rule_slot;
		logic [3:0]  entry_slot;
		logic        filter_is_length;
		logic [9:0]  filter_position;
		logic [15:0] filter_value;
		logic [3:0]  field_kind;
		logic [4:0]  filters_in_rule;
		logic [4:0]  fields_in_rule;
		logic [7:0]  data_byte;
		logic        end_of_packet;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [2:0]  matched_rule;
		logic [3:0]  field_number;
		logic [10:0] field_offset;
		logic [3:0]  decoded_kind;
		logic [63:0] field_value;
		logic [10:0] byte_count;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] index;
		logic [3:0] data;
	} cfg_item_t;

	function automatic logic [3:0] kind_size(input logic [3:0] k);
		if (k <= 4'd1) return 4'd1;
		if (k <= 4'd5) return 4'd2;
		if (k <= 4'd10) return 4'd4;
		if (k == 4'd11) return 4'd8;
		return 4'd0;
	endfunction
endpackage
`default_nettype wire

/* design/prmfe_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface prmfe_in_if;
	logic valid;
	logic ready;
	prmfe_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface prmfe_out_if;
	logic valid;
	logic ready;
	prmfe_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface prmfe_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [3:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

/* design/packet_rule_match_field_extract.sv */
`timescale 1ns / 1ps
`default_nettype none
// Rule matcher and field extractor. The input is ready whenever the block is idle, so table
// writes and non-final packet bytes are taken even while a result beat still waits in the
// output register. After the end-of-packet beat the block walks the rules in slot order.
// Each filter goes through an issue step, a filter memory read, and a packet byte read and
// compare; a further rule check then either moves on past a failing rule or starts the field
// walk of a passing one. A failing rule is left at its first failing filter. Each field then
// goes through a check, registered byte reads and an emit step; a short field or a type code
// with no bytes goes to its emit step without reading bytes. A closing step emits the
// trailing count, if any, and returns to idle; the no-rule result is emitted by the rule
// check. Every step that loads a result beat, and the rule and field checks themselves, wait
// while an earlier beat is not yet taken. No input beat is accepted during the walk.
// Memories are not cleared; reading unwritten table entries gives undefined fields.
module packet_rule_match_field_extract (
	input wire logic clk,
	input wire logic arst_n,
	prmfe_in_if.sink   in_ch,
	prmfe_out_if.source out_ch,
	prmfe_cfg_if.sink  cfg
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RULE  = 7'b0000010,
		S_FRD   = 7'b0000100,
		S_FCHK  = 7'b0001000,
		S_FLD   = 7'b0010000,
		S_BYTE  = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [7:0]  pkt_mem [prmfe_pkg::PACKET_BYTES];
	logic [26:0] flt_mem [prmfe_pkg::RULE_SLOTS*prmfe_pkg::FILTERS_PER_RULE];
	logic [3:0]  fld_mem [prmfe_pkg::RULE_SLOTS*prmfe_pkg::FIELDS_PER_RULE];
	logic [4:0]  nflt_q [prmfe_pkg::RULE_SLOTS];
	logic [4:0]  nfld_q [prmfe_pkg::RULE_SLOTS];

	logic [prmfe_pkg::LW-1:0] len_q, off_q;
	logic [3:0] rule_count_q;
	logic       parser_on_q;
	logic [prmfe_pkg::RW-1:0] rule_q;
	logic [4:0] fi_q;
	logic [4:0] di_q;
	logic [26:0] flt_rd_q;
	logic [7:0]  pkt_rd_q;
	logic [3:0]  kind_rd_q;
	logic [3:0]  bcnt_q;
	logic [63:0] acc_q;
	logic        fail_q;
	prmfe_pkg::out_item_t out_q;
	logic        out_v_q;

	logic acc_in, acc_out;
	assign in_ch.ready = (state_q == S_IDLE);
	assign acc_in  = in_ch.valid && in_ch.ready;
	assign acc_out = out_v_q && out_ch.ready;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;
	assign cfg.ready = 1'b1;

	// Packet memory read address, driven by the walk.
	logic [prmfe_pkg::PAW-1:0] pkt_ra;
	logic [prmfe_pkg::LW-1:0]  byte_addr;
	assign byte_addr = off_q + prmfe_pkg::LW'(bcnt_q);
	always_comb begin
		if (state_q == S_FRD || state_q == S_FCHK) pkt_ra = flt_rd_q[25:16];
		else pkt_ra = byte_addr[prmfe_pkg::PAW-1:0];
	end

	always_ff @(posedge clk) begin
		pkt_rd_q <= pkt_mem[pkt_ra];
		flt_rd_q <= flt_mem[{rule_q, fi_q[prmfe_pkg::FW-1:0]}];
		kind_rd_q <= fld_mem[{rule_q, di_q[prmfe_pkg::DW-1:0]}];
		if (acc_in) begin
			unique case (in_ch.data.operation)
				prmfe_pkg::OP_FILTER:
					flt_mem[{in_ch.data.rule_slot, in_ch.data.entry_slot}] <=
						{in_ch.data.filter_is_length, in_ch.data.filter_position,
						 in_ch.data.filter_value};
				prmfe_pkg::OP_FIELD:
					fld_mem[{in_ch.data.rule_slot, in_ch.data.entry_slot}] <=
						in_ch.data.field_kind;
				prmfe_pkg::OP_COUNTS: ;
				prmfe_pkg::OP_BYTE:
					if (len_q < prmfe_pkg::LW'(prmfe_pkg::PACKET_BYTES))
						pkt_mem[len_q[prmfe_pkg::PAW-1:0]] <= in_ch.data.data_byte;
				default: ;
			endcase
		end
	end

	logic [3:0] ksz;
	logic [prmfe_pkg::LW-1:0] avail;
	logic [4:0] nfld_lim;
	assign ksz = prmfe_pkg::kind_size(kind_rd_q);
	assign avail = len_q - off_q;
	assign nfld_lim = nfld_q[rule_q];

	// The output register may be reloaded when it is empty or its beat leaves this cycle.
	logic out_free;
	logic rule_none;
	logic fld_done;
	logic out_load;
	assign out_free = !out_v_q || acc_out;
	// No rule left to check: parser off, count reached, or the last slot has failed.
	assign rule_none = !parser_on_q || ({1'b0, rule_q} >= rule_count_q) ||
		(fail_q && (32'(rule_q) == prmfe_pkg::RULE_SLOTS - 1));
	assign fld_done = (di_q >= nfld_lim) || (off_q >= len_q);
	assign out_load = out_free && ((state_q == S_RULE && rule_none) ||
		(state_q == S_FLD && fld_done && off_q < len_q) || state_q == S_EMIT);

	function automatic logic [63:0] finish(input logic [3:0] k, input logic [63:0] a);
		logic [63:0] v;
		v = a;
		unique case (k)
			4'd1: v = {{56{a[7]}}, a[7:0]};
			4'd3: v = {{48{a[15]}}, a[15:0]};
			4'd4: v = {48'd0, a[7:0], a[15:8]};
			4'd5: v = {{48{a[7]}}, a[7:0], a[15:8]};
			4'd7: v = {{32{a[31]}}, a[31:0]};
			4'd8: v = {32'd0, a[7:0], a[15:8], a[23:16], a[31:24]};
			4'd9: v = {{32{a[7]}}, a[7:0], a[15:8], a[23:16], a[31:24]};
			4'd12, 4'd13, 4'd14, 4'd15: v = 64'd0;
			default: v = a;
		endcase
		return v;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q <= '0;
			rule_count_q <= '0;
			parser_on_q <= 1'b0;
			out_v_q <= 1'b0;
			out_q <= '0;
			for (int i = 0; i < prmfe_pkg::RULE_SLOTS; i++) begin
				nflt_q[i] <= '0;
				nfld_q[i] <= '0;
			end
			rule_q <= '0; fi_q <= '0; di_q <= '0; off_q <= '0; bcnt_q <= '0;
			acc_q <= '0; fail_q <= 1'b0;
		end else begin
			out_v_q <= out_load || (out_v_q && !acc_out);
			if (cfg.valid) begin
				if (cfg.index == {1'b0, prmfe_pkg::REG_RULE_COUNT}) rule_count_q <= cfg.wdata;
				else if (cfg.index == {1'b0, prmfe_pkg::REG_PARSER_ON})
					parser_on_q <= cfg.wdata[0];
			end
			unique case (state_q)
				S_IDLE: if (acc_in) begin
					if (in_ch.data.operation == prmfe_pkg::OP_COUNTS) begin
						nflt_q[in_ch.data.rule_slot] <=
							(in_ch.data.filters_in_rule > 5'(prmfe_pkg::FILTERS_PER_RULE))
							? 5'(prmfe_pkg::FILTERS_PER_RULE) : in_ch.data.filters_in_rule;
						nfld_q[in_ch.data.rule_slot] <=
							(in_ch.data.fields_in_rule > 5'(prmfe_pkg::FIELDS_PER_RULE))
							? 5'(prmfe_pkg::FIELDS_PER_RULE) : in_ch.data.fields_in_rule;
					end
					if (in_ch.data.operation == prmfe_pkg::OP_BYTE) begin
						if (len_q < prmfe_pkg::LW'(prmfe_pkg::PACKET_BYTES))
							len_q <= len_q + 1'b1;
						if (in_ch.data.end_of_packet) begin
							rule_q <= '0; fi_q <= '0; fail_q <= 1'b0;
							state_q <= S_RULE;
						end
					end
				end
				S_RULE: if (out_free) begin
					// Decide whether the current rule is done checking.
					if (rule_none) begin
						out_q <= '{prmfe_pkg::RK_NONE, 3'd0, 4'd0, 11'd0, 4'd0, 64'd0,
							11'd0, 1'b1};
						len_q <= '0;
						state_q <= S_IDLE;
					end else if (fail_q) begin
						fail_q <= 1'b0; fi_q <= '0;
						rule_q <= rule_q + 1'b1;
					end else if (fi_q >= nflt_q[rule_q]) begin
						di_q <= '0; off_q <= '0; bcnt_q <= '0; acc_q <= '0;
						state_q <= S_FLD;
					end else state_q <= S_FRD;
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (flt_rd_q[26]) begin
						if (len_q != prmfe_pkg::LW'(flt_rd_q[15:0]) || flt_rd_q[15:11] != 5'd0)
							fail_q <= 1'b1;
					end else if (prmfe_pkg::LW'(flt_rd_q[25:16]) >= len_q ||
					             {8'd0, pkt_rd_q} != flt_rd_q[15:0]) fail_q <= 1'b1;
					fi_q <= fi_q + 1'b1;
					state_q <= S_RULE;
				end
				S_FLD: if (out_free) begin
					// The type read for di_q is issued here and used from the next cycle.
					if (fld_done) begin
						if (off_q < len_q)
							out_q <= '{prmfe_pkg::RK_TRAIL, rule_q, 4'd0, off_q, 4'd0, 64'd0,
								avail, 1'b1};
						len_q <= '0;
						state_q <= S_IDLE;
					end else state_q <= S_BYTE;
				end
				S_BYTE: begin
					// Pipeline: address byte_addr issued, data arrives next cycle.
					if (bcnt_q != 0)
						acc_q <= acc_q | ({56'd0, pkt_rd_q} << (8 * (bcnt_q - 1'b1)));
					if (prmfe_pkg::LW'(ksz) > avail || bcnt_q == ksz) state_q <= S_EMIT;
					else bcnt_q <= bcnt_q + 1'b1;
				end
				S_EMIT: if (out_free) begin
					if (prmfe_pkg::LW'(ksz) > avail) begin
						out_q <= '{prmfe_pkg::RK_SHORT, rule_q, di_q[3:0], off_q, kind_rd_q,
							64'd0, avail, 1'b1};
						off_q <= len_q;
					end else begin
						// Last when the field uses up the packet; otherwise more follows.
						out_q <= '{prmfe_pkg::RK_FIELD, rule_q, di_q[3:0], off_q, kind_rd_q,
							finish(kind_rd_q, acc_q), 11'd0,
							(off_q + prmfe_pkg::LW'(ksz) >= len_q)};
						off_q <= off_q + prmfe_pkg::LW'(ksz);
					end
					di_q <= di_q + 1'b1; bcnt_q <= '0; acc_q <= '0;
					state_q <= S_FLD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ch.ready) else $error("input taken during walk");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ch.ready) |=> out_v_q) else $error("result beat dropped");
	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= prmfe_pkg::LW'(prmfe_pkg::PACKET_BYTES)) else $error("length overflow");
`endif
endmodule
`default_nettype wire

/* bench/tb_packet_rule_match_field_extract.sv */
`timescale 1ns / 1ps
module tb_packet_rule_match_field_extract;

	// Field type codes as the block numbers them.
	localparam int K_U8 = 0, K_S8 = 1, K_U16LE = 2, K_S16LE = 3, K_U16BE = 4, K_S16BE = 5;
	localparam int K_U32LE = 6, K_S32LE = 7, K_U32BE = 8, K_S32BE = 9, K_FLOAT = 10;
	localparam int K_DOUBLE = 11;
	// Cycles allowed for a rule walk to finish once the last result has been seen.
	localparam int WALK_SETTLE = 600;
	localparam int LONG_STALL = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prmfe_in_if  in_ch ();
	prmfe_out_if out_ch ();
	prmfe_cfg_if cfg_ch ();

	packet_rule_match_field_extract i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg_ch)
	);

	// Beats waiting to be offered, and the results the block owes us, oldest first.
	prmfe_pkg::in_item_t  pending_beats[$];
	prmfe_pkg::out_item_t owed_results[$];

	// Predictor copy of the block state, updated on every accepted beat.
	logic [26:0] filt_mem[prmfe_pkg::RULE_SLOTS][prmfe_pkg::FILTERS_PER_RULE];
	logic [3:0]  kind_mem[prmfe_pkg::RULE_SLOTS][prmfe_pkg::FIELDS_PER_RULE];
	int          filt_count[prmfe_pkg::RULE_SLOTS];
	int          fields_used[prmfe_pkg::RULE_SLOTS];
	logic [7:0]  pkt_mem[prmfe_pkg::PACKET_BYTES];
	int          pkt_len;
	int          active_rules;
	logic        parsing;

	// Stimulus-side shadow of what has been written, so that the counts never reach an
	// entry that was never written and packets can be shaped to satisfy a rule.
	logic [26:0] gen_filt[prmfe_pkg::RULE_SLOTS][prmfe_pkg::FILTERS_PER_RULE];
	logic [15:0] gen_filt_seen[prmfe_pkg::RULE_SLOTS];
	logic [15:0] gen_kind_seen[prmfe_pkg::RULE_SLOTS];
	int          gen_filt_count[prmfe_pkg::RULE_SLOTS];

	int  send_idle = 0;
	int  recv_idle = 0;
	bit  send_hold = 1'b0;
	bit  stall_req = 1'b0;
	int  stall_left = 0;
	bit  in_taken = 1'b0;
	int  errors = 0;
	int  packets_closed = 0;
	int  results_checked = 0;
	int  beats_taken = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#8000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic int width_of(input logic [3:0] k);
		if (k <= K_S8) return 1;
		if (k <= K_S16BE) return 2;
		if (k <= K_FLOAT) return 4;
		if (k == K_DOUBLE) return 8;
		return 0;
	endfunction

	// Pull a field out of the stored packet. Floats come through as raw little-endian bits.
	function automatic logic [63:0] field_bits(input logic [3:0] k, input int off);
		logic [63:0] v;
		v = '0;
		case (k)
			K_U8: v = {56'd0, pkt_mem[off]};
			K_S8: v = {{56{pkt_mem[off][7]}}, pkt_mem[off]};
			K_U16LE: v = {48'd0, pkt_mem[off + 1], pkt_mem[off]};
			K_S16LE: v = {{48{pkt_mem[off + 1][7]}}, pkt_mem[off + 1], pkt_mem[off]};
			K_U16BE: v = {48'd0, pkt_mem[off], pkt_mem[off + 1]};
			K_S16BE: v = {{48{pkt_mem[off][7]}}, pkt_mem[off], pkt_mem[off + 1]};
			K_U32LE, K_FLOAT: v = {32'd0, pkt_mem[off + 3], pkt_mem[off + 2],
				pkt_mem[off + 1], pkt_mem[off]};
			K_S32LE: v = {{32{pkt_mem[off + 3][7]}}, pkt_mem[off + 3], pkt_mem[off + 2],
				pkt_mem[off + 1], pkt_mem[off]};
			K_U32BE: v = {32'd0, pkt_mem[off], pkt_mem[off + 1], pkt_mem[off + 2],
				pkt_mem[off + 3]};
			K_S32BE: v = {{32{pkt_mem[off][7]}}, pkt_mem[off], pkt_mem[off + 1],
				pkt_mem[off + 2], pkt_mem[off + 3]};
			K_DOUBLE: for (int i = 0; i < 8; i++) v[8 * i +: 8] = pkt_mem[off + i];
			default: v = '0;
		endcase
		return v;
	endfunction

	// A byte test with a value above 255 can never pass, which the zero-extended compare gives.
	function automatic bit rule_holds(input int r);
		logic [26:0] f;
		for (int i = 0; i < filt_count[r]; i++) begin
			f = filt_mem[r][i];
			if (f[26]) begin
				if (pkt_len != int'(f[15:0])) return 1'b0;
			end else begin
				if (int'(f[25:16]) >= pkt_len) return 1'b0;
				if (f[15:0] != {8'd0, pkt_mem[f[25:16]]}) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Work out every result that an end-of-packet beat causes and queue them.
	task automatic close_packet();
		prmfe_pkg::out_item_t res[$];
		prmfe_pkg::out_item_t o;
		int        lim, off, sz, avail;
		bit        hit;
		lim = (active_rules > prmfe_pkg::RULE_SLOTS) ? prmfe_pkg::RULE_SLOTS : active_rules;
		hit = 1'b0;
		if (parsing) begin
			for (int r = 0; r < lim && !hit; r++) begin
				if (rule_holds(r)) begin
					hit = 1'b1;
					off = 0;
					for (int fi = 0; fi < fields_used[r] && off < pkt_len; fi++) begin
						sz = width_of(kind_mem[r][fi]);
						avail = pkt_len - off;
						o = '0;
						o.matched_rule = 3'(r);
						o.field_number = 4'(fi);
						o.field_offset = 11'(off);
						o.decoded_kind = kind_mem[r][fi];
						if (sz > avail) begin
							// Short field: swallows what is left and ends the walk.
							o.result_kind = prmfe_pkg::RK_SHORT;
							o.byte_count = 11'(avail);
							off = pkt_len;
						end else begin
							o.result_kind = prmfe_pkg::RK_FIELD;
							o.field_value = field_bits(kind_mem[r][fi], off);
							off += sz;
						end
						res.push_back(o);
					end
					if (off < pkt_len) begin
						o = '0;
						o.result_kind = prmfe_pkg::RK_TRAIL;
						o.matched_rule = 3'(r);
						o.field_offset = 11'(off);
						o.byte_count = 11'(pkt_len - off);
						res.push_back(o);
					end
				end
			end
		end
		if (!hit) begin
			o = '0;
			o.result_kind = prmfe_pkg::RK_NONE;
			res.push_back(o);
		end
		o = res.pop_back();
		o.last_result = 1'b1;
		res.push_back(o);
		foreach (res[i]) owed_results.push_back(res[i]);
		packets_closed++;
	endtask

	task automatic absorb_beat(input prmfe_pkg::in_item_t it);
		int nf, nd;
		case (it.operation)
			prmfe_pkg::OP_FILTER: filt_mem[it.rule_slot][it.entry_slot] =
				{it.filter_is_length, it.filter_position, it.filter_value};
			prmfe_pkg::OP_FIELD: kind_mem[it.rule_slot][it.entry_slot] = it.field_kind;
			prmfe_pkg::OP_COUNTS: begin
				nf = it.filters_in_rule;
				nd = it.fields_in_rule;
				filt_count[it.rule_slot] = (nf > prmfe_pkg::FILTERS_PER_RULE)
					? prmfe_pkg::FILTERS_PER_RULE : nf;
				fields_used[it.rule_slot] = (nd > prmfe_pkg::FIELDS_PER_RULE)
					? prmfe_pkg::FIELDS_PER_RULE : nd;
			end
			default: begin
				// Bytes past the store are dropped, but the end mark still closes the packet.
				if (pkt_len < prmfe_pkg::PACKET_BYTES) begin
					pkt_mem[pkt_len] = it.data_byte;
					pkt_len++;
				end
				if (it.end_of_packet) begin
					close_packet();
					pkt_len = 0;
				end
			end
		endcase
	endtask

	// Sender: a new beat is offered at the falling edge once the previous one has gone.
	always @(negedge clk) begin
		if (!in_ch.valid || in_taken) begin
			in_taken = 1'b0;
			if (arst_n && !send_hold && pending_beats.size() > 0 &&
					$urandom_range(99) >= send_idle) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_beats.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
		out_ch.ready <= arst_n && (stall_left == 0) && ($urandom_range(99) >= recv_idle);
	end

	// The long receiver stall is counted here, apart from the stimulus.
	always @(posedge clk) begin
		if (stall_req) begin
			stall_left = LONG_STALL;
			stall_req = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
		end
	end

	// Input monitor feeds the predictor; output monitor checks against the oldest result owed.
	always @(posedge clk) begin
		prmfe_pkg::out_item_t want;
		prmfe_pkg::out_item_t got;
		if (in_ch.valid && in_ch.ready) begin
			in_taken = 1'b1;
			beats_taken++;
			absorb_beat(in_ch.data);
		end
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (owed_results.size() == 0) begin
				report("unexpected result beat", got.field_value, '0);
			end else begin
				want = owed_results.pop_front();
				results_checked++;
				if (got.result_kind != want.result_kind)
					report("result_kind", got.result_kind, want.result_kind);
				if (got.matched_rule != want.matched_rule)
					report("matched_rule", got.matched_rule, want.matched_rule);
				if (got.field_number != want.field_number)
					report("field_number", got.field_number, want.field_number);
				if (got.field_offset != want.field_offset)
					report("field_offset", got.field_offset, want.field_offset);
				if (got.decoded_kind != want.decoded_kind)
					report("decoded_kind", got.decoded_kind, want.decoded_kind);
				if (got.field_value != want.field_value)
					report("field_value", got.field_value, want.field_value);
				if (got.byte_count != want.byte_count)
					report("byte_count", got.byte_count, want.byte_count);
				if (got.last_result != want.last_result)
					report("last_result", got.last_result, want.last_result);
			end
		end
	end

	// Every beat starts with random junk in the fields its operation ignores,
	// so each input bit is seen at both values.
	function automatic prmfe_pkg::in_item_t noisy_beat(input prmfe_pkg::op_t op);
		logic [63:0] rnd;
		prmfe_pkg::in_item_t it;
		rnd = {$urandom, $urandom};
		it = rnd[$bits(prmfe_pkg::in_item_t)-1:0];
		it.operation = op;
		return it;
	endfunction

	function automatic int written_prefix(input logic [15:0] seen);
		int n;
		n = 0;
		while (n < 16 && seen[n]) n++;
		return n;
	endfunction

	task automatic put_filter(input int r, input int e, input bit is_len, input int pos,
			input int val);
		prmfe_pkg::in_item_t it;
		it = noisy_beat(prmfe_pkg::OP_FILTER);
		it.rule_slot = 3'(r);
		it.entry_slot = 4'(e);
		it.filter_is_length = is_len;
		it.filter_position = 10'(pos);
		it.filter_value = 16'(val);
		gen_filt[r][e] = {it.filter_is_length, it.filter_position, it.filter_value};
		gen_filt_seen[r][e] = 1'b1;
		pending_beats.push_back(it);
	endtask

	task automatic put_kind(input int r, input int e, input int k);
		prmfe_pkg::in_item_t it;
		it = noisy_beat(prmfe_pkg::OP_FIELD);
		it.rule_slot = 3'(r);
		it.entry_slot = 4'(e);
		it.field_kind = 4'(k);
		gen_kind_seen[r][e] = 1'b1;
		pending_beats.push_back(it);
	endtask

	// Counts are held back to the entries already written; counts above the table size
	// are only used once a rule is fully written, where they saturate.
	task automatic put_counts(input int r, input int nf, input int nd);
		prmfe_pkg::in_item_t it;
		int       pf, pd;
		pf = written_prefix(gen_filt_seen[r]);
		pd = written_prefix(gen_kind_seen[r]);
		if (nf > pf && pf < 16) nf = $urandom_range(pf, 0);
		if (nd > pd && pd < 16) nd = $urandom_range(pd, 0);
		it = noisy_beat(prmfe_pkg::OP_COUNTS);
		it.rule_slot = 3'(r);
		it.filters_in_rule = 5'(nf);
		it.fields_in_rule = 5'(nd);
		gen_filt_count[r] = (nf > 16) ? 16 : nf;
		pending_beats.push_back(it);
	endtask

	task automatic put_bytes(input logic [7:0] bytes[$]);
		prmfe_pkg::in_item_t it;
		foreach (bytes[i]) begin
			it = noisy_beat(prmfe_pkg::OP_BYTE);
			it.data_byte = bytes[i];
			it.end_of_packet = (i == bytes.size() - 1);
			pending_beats.push_back(it);
		end
	endtask

	// Build a packet, usually shaped so that the filters of one rule pass.
	task automatic put_packet(input int len, input bit shaped, input int r);
		logic [7:0]  bytes[$];
		logic [26:0] f;
		if (shaped) begin
			for (int i = 0; i < gen_filt_count[r]; i++) begin
				f = gen_filt[r][i];
				if (f[26] && f[15:0] >= 1 && f[15:0] <= 64) len = f[15:0];
			end
		end
		for (int i = 0; i < len; i++) bytes.push_back($urandom_range(255, 0));
		if (shaped) begin
			for (int i = 0; i < gen_filt_count[r]; i++) begin
				f = gen_filt[r][i];
				if (!f[26] && f[25:16] < len && f[15:0] < 256) bytes[f[25:16]] = f[7:0];
			end
		end
		put_bytes(bytes);
	endtask

	task automatic put_random_table_write();
		int r, e, sel;
		r = $urandom_range(prmfe_pkg::RULE_SLOTS - 1, 0);
		sel = $urandom_range(2, 0);
		if (sel == 0) begin
			e = written_prefix(gen_filt_seen[r]);
			if (e >= 16 || $urandom_range(99) < 30) e = $urandom_range(15, 0);
			if ($urandom_range(99) < 30)
				put_filter(r, e, 1'b1, $urandom_range(1023, 0),
					($urandom_range(99) < 80) ? $urandom_range(40, 1) : $urandom_range(65535, 0));
			else
				put_filter(r, e, 1'b0,
					($urandom_range(99) < 80) ? $urandom_range(39, 0) : $urandom_range(1023, 0),
					($urandom_range(99) < 85) ? $urandom_range(255, 0) : $urandom_range(65535, 0));
		end else if (sel == 1) begin
			e = written_prefix(gen_kind_seen[r]);
			if (e >= 16 || $urandom_range(99) < 30) e = $urandom_range(15, 0);
			put_kind(r, e, $urandom_range(15, 0));
		end else begin
			put_counts(r, ($urandom_range(99) < 60) ? $urandom_range(3, 0) : $urandom_range(31, 0),
				$urandom_range(31, 0));
		end
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [3:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == {1'b0, prmfe_pkg::REG_RULE_COUNT}) active_rules = val;
		else parsing = val[0];
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Quiet point: every beat sent, every result back, and time for any walk to finish.
	task automatic drain();
		while (pending_beats.size() > 0 || in_ch.valid || owed_results.size() > 0)
			@(posedge clk);
		repeat (WALK_SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [7:0] bytes[$];
		int         phase_rules[9] = '{8, 15, 1, 0, 3, 8, 8, 5, 15};
		bit         phase_parse[9] = '{1, 1, 1, 1, 1, 0, 1, 1, 1};
		int         budget, r;

		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		pkt_len = 0;
		active_rules = 0;
		parsing = 1'b0;
		for (int i = 0; i < prmfe_pkg::RULE_SLOTS; i++) begin
			filt_count[i] = 0;
			fields_used[i] = 0;
			gen_filt_count[i] = 0;
			gen_filt_seen[i] = '0;
			gen_kind_seen[i] = '0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. Rule 0 decodes one field of every type code, the unknown codes too,
		// and its count of 31 saturates at the table size. Rule 1 holds a byte test whose
		// value lies above 255, so it can never pass.
		for (int k = 0; k < 16; k++) put_kind(0, k, k);
		put_counts(0, 0, 31);
		put_filter(1, 0, 1'b0, 0, 16'h01FF);
		put_counts(1, 1, 0);
		// With the parser still off at its reset value, a packet gives the no-rule result.
		put_bytes('{8'h00, 8'hFF});
		drain();
		write_register({1'b0, prmfe_pkg::REG_PARSER_ON}, 4'd1);
		write_register({1'b0, prmfe_pkg::REG_RULE_COUNT}, 4'd1);
		// Sign bits set throughout, long enough for every field plus trailing bytes.
		bytes = {};
		for (int i = 0; i < 60; i++) bytes.push_back((i % 2) ? 8'hFF : 8'h80);
		put_bytes(bytes);
		// Three bytes: the third field, a 16-bit one, runs short of bytes.
		put_bytes('{8'h7F, 8'h01, 8'hAA});
		put_bytes('{8'h00});
		drain();

		// Random phases: thirds with receiver-heavy idling, sender-heavy idling, then none.
		for (int ph = 0; ph < 9; ph++) begin
			send_idle = (ph < 3) ? 32 : (ph < 6) ? 87 : 0;
			recv_idle = (ph < 3) ? 87 : (ph < 6) ? 32 : 0;
			write_register({1'b0, prmfe_pkg::REG_RULE_COUNT}, 4'(phase_rules[ph]));
			write_register({1'b0, prmfe_pkg::REG_PARSER_ON}, 4'(phase_parse[ph]));
			budget = pending_beats.size() + 38;
			while (pending_beats.size() < budget) begin
				if ($urandom_range(99) < 55) begin
					put_random_table_write();
				end else begin
					r = $urandom_range(prmfe_pkg::RULE_SLOTS - 1, 0);
					put_packet(($urandom_range(99) < 80) ? $urandom_range(12, 1)
						: $urandom_range(40, 1), $urandom_range(99) < 80, r);
				end
			end
			if (ph == 4) begin
				// Hold the output off for a long stretch while beats keep coming, so the
				// block fills and backs up onto its input.
				@(negedge clk);
				stall_req = 1'b1;
			end
			if (ph == 2) begin
				// Stop the sender mid-phase until everything owed has come back.
				while (pending_beats.size() > budget / 2) @(posedge clk);
				send_hold = 1'b1;
				while (owed_results.size() > 0 || in_ch.valid) @(posedge clk);
				send_hold = 1'b0;
			end
			drain();
		end

		$display("Covered %0d beats, %0d packets, %0d result beats checked over 9 settings.",
			beats_taken, packets_closed, results_checked);
		$display("Register extremes, saturating counts, short fields and a long output hold-off.");
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
